// ----- hdl/pba_pkg.sv -----
// ----------------------------------------------------------------------------
// pba_pkg
// Shared types, codes and sizes of the pool block allocator.
// ----------------------------------------------------------------------------
package pba_pkg;

    // default sizing of the pool
    localparam int MAX_CHUNKS_DEF           = 16;
    localparam int MAX_BLOCKS_PER_CHUNK_DEF = 64;
    localparam int ALIGN_SHIFT_DEF          = 3;

    // block index space and free-list links
    localparam int          LIST_DEPTH = 1024;
    localparam int          IDX_W      = 10;
    localparam int          HEAD_W     = 11;
    localparam logic [10:0] NULL_MARK  = 11'd1024;

    // field widths
    localparam int COUNT_W = 11;
    localparam int BYTES_W = 27;
    localparam int OBJ_W   = 16;
    localparam int BLK_W   = 7;
    localparam int OVH_W   = 8;
    localparam int SIZE_W  = OBJ_W + 1;
    localparam int PAGE_W  = SIZE_W + BLK_W + 1;
    localparam int CFG_W   = 16;
    localparam int CFG_IDX_W = 2;

    // stream packing
    localparam int S_DATA_W = 16;
    localparam int S_USER_W = 3;
    localparam int M_DATA_W = 80;
    localparam int M_USER_W = 3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_OBJECT_BYTES     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BLOCKS_PER_CHUNK = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CHUNK_OVERHEAD   = 2'd2;

    // register reset values
    localparam logic [OBJ_W-1:0] OBJECT_BYTES_RST = 16'd8;
    localparam logic [BLK_W-1:0] BLOCKS_RST       = 7'd64;
    localparam logic [OVH_W-1:0] OVERHEAD_RST     = 8'd16;

    typedef enum logic [1:0] {
        FN_ALLOC = 2'd0,
        FN_FREE  = 2'd1,
        FN_RESET = 2'd2,
        FN_NOP   = 2'd3
    } func_t;

    typedef enum logic [2:0] {
        ST_FREE_LIST = 3'd0,
        ST_BUMP      = 3'd1,
        ST_NEW_CHUNK = 3'd2,
        ST_OOM       = 3'd3,
        ST_DONE      = 3'd4
    } status_t;

endpackage

// ----- hdl/pool_block_allocator_core.sv -----
// ----------------------------------------------------------------------------
// pool_block_allocator_core
// Fixed-size block allocator: LIFO free list, bump pointer, chunk claiming.
// ----------------------------------------------------------------------------
// Usage
//   Requests arrive on the s_ stream: s_tuser carries the operation and the
//   null flag, s_tdata the block index to free. Every request yields exactly
//   one word on the m_ stream: the granted index and the running totals in
//   m_tdata, the status code in m_tuser.
//   Throughput is one request per cycle while the output is not stalled. The
//   pool state is updated in the cycle of acceptance; the free-list link of the
//   current head is kept prefetched from the link RAM read port (with a bypass
//   for a free that lands on the address being read), so a pop never waits.
//   From acceptance to m_tvalid a request passes the state stage, then one
//   stage for the byte totals (one multiplier each).
//   A stalled receiver holds the output word; one more request is taken into
//   the state stage, after which s_tready drops until the output moves.
//   Reset (aresetn low, synchronous) empties the pool and restores register
//   defaults; the link RAM is not cleared, so no reset pass is needed.
//   Configuration writes are taken at any edge with cfg_wr_en high and must
//   only occur while the block is idle.
// ----------------------------------------------------------------------------
module pool_block_allocator_core
    import pba_pkg::*;
#(
    parameter int MAX_CHUNKS           = MAX_CHUNKS_DEF,
    parameter int MAX_BLOCKS_PER_CHUNK = MAX_BLOCKS_PER_CHUNK_DEF,
    parameter int ALIGN_SHIFT          = ALIGN_SHIFT_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,

    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata,

    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_DATA_W-1:0]  s_tdata,   // [9:0] block_index, [15:10] zero
    input  logic [S_USER_W-1:0]  s_tuser,   // [1:0] func, [2] is_null

    output logic                 m_tvalid,
    input  logic                 m_tready,
    // [9:0] granted_index, [20:10] objects_allocated, [47:21] bytes_allocated,
    // [74:48] bytes_claimed, [79:75] zero
    output logic [M_DATA_W-1:0]  m_tdata,
    output logic [M_USER_W-1:0]  m_tuser    // [2:0] status
);

    localparam int CHUNK_W = $clog2(MAX_CHUNKS + 1);
    localparam int PROD_W  = CHUNK_W + PAGE_W + 1;
    localparam logic [SIZE_W-1:0] ALIGN_MASK = SIZE_W'((1 << ALIGN_SHIFT) - 1);

    // configuration
    logic [OBJ_W-1:0]  object_bytes_reg;
    logic [BLK_W-1:0]  blocks_reg;
    logic [OVH_W-1:0]  overhead_reg;
    logic [SIZE_W-1:0] size_c;
    logic [BLK_W-1:0]  eff_blocks_c;
    logic [SIZE_W-1:0] size_reg;
    logic [PAGE_W-1:0] page_reg;

    // pool state
    logic [HEAD_W-1:0]  free_head_reg, free_head_next;
    logic [CHUNK_W-1:0] chunks_reg, chunks_next;
    logic [BLK_W-1:0]   bump_reg, bump_next;
    logic [COUNT_W-1:0] count_reg, count_next;

    // link RAM
    logic [HEAD_W-1:0] link_mem [LIST_DEPTH];
    logic [HEAD_W-1:0] link_rd_reg;
    logic              byp_valid_reg;
    logic [HEAD_W-1:0] byp_data_reg;
    logic [HEAD_W-1:0] head_link;
    logic              link_wr_en;
    logic [IDX_W-1:0]  rd_addr;

    // request decode
    logic             s_accept;
    func_t            s_func;
    logic             s_is_null;
    logic [IDX_W-1:0] s_index;
    logic [IDX_W-1:0] granted_c;
    status_t          status_c;
    logic [31:0]      bump_grant;
    logic [31:0]      chunk_grant;

    // state stage
    logic               st1_valid_reg;
    logic [IDX_W-1:0]   st1_granted_reg;
    status_t            st1_status_reg;
    logic [COUNT_W-1:0] st1_count_reg;
    logic [CHUNK_W-1:0] st1_chunks_reg;

    // output stage
    logic               out_valid_reg;
    logic               out_adv;
    logic [IDX_W-1:0]   out_granted_reg;
    status_t            out_status_reg;
    logic [COUNT_W-1:0] out_count_reg;
    logic [BYTES_W-1:0] out_alloc_reg;
    logic [BYTES_W-1:0] out_claimed_reg;
    logic [COUNT_W+SIZE_W-1:0] alloc_prod;
    logic [PROD_W-1:0]         claimed_prod;

    // ------------------------------------------------------------------
    // configuration registers and derived sizes
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            object_bytes_reg <= OBJECT_BYTES_RST;
            blocks_reg       <= BLOCKS_RST;
            overhead_reg     <= OVERHEAD_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_OBJECT_BYTES:     object_bytes_reg <= cfg_wdata[OBJ_W-1:0];
                REG_BLOCKS_PER_CHUNK: blocks_reg       <= cfg_wdata[BLK_W-1:0];
                REG_CHUNK_OVERHEAD:   overhead_reg     <= cfg_wdata[OVH_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        size_c = (SIZE_W'(object_bytes_reg) + ALIGN_MASK) & ~ALIGN_MASK;
        if (blocks_reg == '0) begin
            eff_blocks_c = BLK_W'(1);
        end else if (32'(blocks_reg) > MAX_BLOCKS_PER_CHUNK) begin
            eff_blocks_c = BLK_W'(MAX_BLOCKS_PER_CHUNK);
        end else begin
            eff_blocks_c = blocks_reg;
        end
    end

    // page size is used one stage after the state update, so a register fits
    always_ff @(posedge aclk) begin
        size_reg <= size_c;
        page_reg <= PAGE_W'(size_c) * PAGE_W'(eff_blocks_c) + PAGE_W'(overhead_reg);
    end

    // ------------------------------------------------------------------
    // pool state update
    // ------------------------------------------------------------------
    assign out_adv   = !out_valid_reg || m_tready;
    assign s_tready  = !st1_valid_reg || out_adv;
    assign s_accept  = s_tvalid && s_tready;
    assign s_func    = func_t'(s_tuser[1:0]);
    assign s_is_null = s_tuser[2];
    assign s_index   = s_tdata[IDX_W-1:0];

    assign head_link   = byp_valid_reg ? byp_data_reg : link_rd_reg;
    assign bump_grant  = 32'(chunks_reg - CHUNK_W'(1)) * 32'(MAX_BLOCKS_PER_CHUNK)
                       + 32'(bump_reg);
    assign chunk_grant = 32'(chunks_reg) * 32'(MAX_BLOCKS_PER_CHUNK);

    always_comb begin
        free_head_next = free_head_reg;
        chunks_next    = chunks_reg;
        bump_next      = bump_reg;
        count_next     = count_reg;
        granted_c      = '0;
        status_c       = ST_DONE;
        link_wr_en     = 1'b0;
        if (s_accept) begin
            unique case (s_func)
                FN_ALLOC: begin
                    if (free_head_reg != NULL_MARK) begin
                        granted_c      = free_head_reg[IDX_W-1:0];
                        free_head_next = head_link;
                        count_next     = count_reg + COUNT_W'(1);
                        status_c       = ST_FREE_LIST;
                    end else if (chunks_reg != '0 && bump_reg < eff_blocks_c) begin
                        granted_c  = bump_grant[IDX_W-1:0];
                        bump_next  = bump_reg + BLK_W'(1);
                        count_next = count_reg + COUNT_W'(1);
                        status_c   = ST_BUMP;
                    end else if (32'(chunks_reg) < MAX_CHUNKS) begin
                        granted_c   = chunk_grant[IDX_W-1:0];
                        chunks_next = chunks_reg + CHUNK_W'(1);
                        bump_next   = BLK_W'(1);
                        count_next  = count_reg + COUNT_W'(1);
                        status_c    = ST_NEW_CHUNK;
                    end else begin
                        status_c = ST_OOM;
                    end
                end
                FN_FREE: begin
                    if (!s_is_null) begin
                        link_wr_en     = 1'b1;
                        free_head_next = {1'b0, s_index};
                        count_next     = count_reg - COUNT_W'(1);
                    end
                end
                FN_RESET: begin
                    free_head_next = NULL_MARK;
                    chunks_next    = '0;
                    bump_next      = '0;
                    count_next     = '0;
                end
                FN_NOP: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            free_head_reg <= NULL_MARK;
            chunks_reg    <= '0;
            bump_reg      <= '0;
            count_reg     <= '0;
            byp_valid_reg <= 1'b0;
        end else begin
            free_head_reg <= free_head_next;
            chunks_reg    <= chunks_next;
            bump_reg      <= bump_next;
            count_reg     <= count_next;
            byp_valid_reg <= link_wr_en;
        end
    end

    // a free writes the address that becomes the new head: forward the old head
    always_ff @(posedge aclk) begin
        byp_data_reg <= free_head_reg;
    end

    // ------------------------------------------------------------------
    // link RAM: always read at the upcoming head
    // ------------------------------------------------------------------
    assign rd_addr = free_head_next[IDX_W-1:0];

    always_ff @(posedge aclk) begin
        if (link_wr_en) begin
            link_mem[s_index] <= free_head_reg;
        end
        link_rd_reg <= link_mem[rd_addr];
    end

    // ------------------------------------------------------------------
    // state stage and output stage
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st1_valid_reg <= 1'b0;
        end else if (s_tready) begin
            st1_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            st1_granted_reg <= granted_c;
            st1_status_reg  <= status_c;
            st1_count_reg   <= count_next;
            st1_chunks_reg  <= chunks_next;
        end
    end

    assign alloc_prod   = st1_count_reg * size_reg;
    assign claimed_prod = PROD_W'(st1_chunks_reg) * PROD_W'(page_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_adv) begin
            out_valid_reg <= st1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_adv && st1_valid_reg) begin
            out_granted_reg <= st1_granted_reg;
            out_status_reg  <= st1_status_reg;
            out_count_reg   <= st1_count_reg;
            out_alloc_reg   <= alloc_prod[BYTES_W-1:0];
            out_claimed_reg <= claimed_prod[BYTES_W-1:0];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = {(M_DATA_W - IDX_W - COUNT_W - 2*BYTES_W)'(0),
                       out_claimed_reg, out_alloc_reg, out_count_reg, out_granted_reg};

endmodule

// ----- hdl/pba_checker.sv -----
// ----------------------------------------------------------------------------
// pba_checker
// Port-level checks of the pool block allocator, bound to the top level.
// ----------------------------------------------------------------------------
module pba_checker
    import pba_pkg::*;
(
    input logic                aclk,
    input logic                aresetn,
    input logic                s_tvalid,
    input logic                s_tready,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [M_DATA_W-1:0] m_tdata,
    input logic [M_USER_W-1:0] m_tuser
);

    // hold a stalled output word
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("output word changed while stalled");

    // no result may be left standing across reset
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

    // only a successful allocate hands out an index
    a_grant_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == ST_OOM || m_tuser == ST_DONE) |-> m_tdata[9:0] == '0)
        else $error("index granted without a successful allocate");

    // bytes allocated follows the object count
    a_bytes_follow_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[20:10] == '0 |-> m_tdata[47:21] == '0)
        else $error("bytes allocated with no live objects");

endmodule

bind pool_block_allocator_core pba_checker u_pba_checker (.*);
